// ===== design/dpsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Drive power state machine package
// Shared state codes, statusword constants and result type.
// ----------------------------------------------------------------------------
package dpsm_pkg;

   localparam int unsigned CW_WIDTH    = 16;
   localparam int unsigned SW_WIDTH    = 16;
   localparam int unsigned STATE_WIDTH = 3;

   // Controlword bit positions and command patterns.
   localparam int unsigned CW_FAULT_RESET_BIT = 7;
   localparam int unsigned CW_ENABLE_VOLT_BIT = 1;
   localparam int unsigned CW_QUICK_STOP_BIT  = 2;
   localparam logic [2:0]  CMD3_SHUTDOWN      = 3'h6;
   localparam logic [2:0]  CMD3_SWITCH_ON     = 3'h7;
   localparam logic [3:0]  CMD4_ENABLE_OP     = 4'hF;
   localparam logic [3:0]  CMD4_DISABLE_OP    = 4'h7;

   localparam logic [SW_WIDTH-1:0] SW_BASE = 16'h0200;

   typedef enum logic [STATE_WIDTH-1:0] {
      ST_NOT_READY   = 3'd0,
      ST_DISABLED    = 3'd1,
      ST_READY       = 3'd2,
      ST_SWITCHED_ON = 3'd3,
      ST_ENABLED     = 3'd4,
      ST_QUICK_STOP  = 3'd5,
      ST_FAULT_REACT = 3'd6,
      ST_FAULT       = 3'd7
   } power_state_type;

   typedef struct packed {
      logic [SW_WIDTH-1:0] status_word;
      power_state_type     state_code;
      logic                op_enabled;
   } dpsm_result_type;

   // Statusword for a given power state, base bits included.
   function automatic logic [SW_WIDTH-1:0] status_of(input power_state_type st);
      logic [SW_WIDTH-1:0] bits;
      case (st)
         ST_NOT_READY:   bits = 16'h0000;
         ST_DISABLED:    bits = 16'h0040;
         ST_READY:       bits = 16'h0031;
         ST_SWITCHED_ON: bits = 16'h0033;
         ST_ENABLED:     bits = 16'h0037;
         ST_QUICK_STOP:  bits = 16'h0017;
         default:        bits = 16'h0008;
      endcase
      return SW_BASE | bits;
   endfunction

endpackage

// ===== design/drive_power_state_machine.sv =====
// ----------------------------------------------------------------------------
// Drive power state machine
// CiA 402 style power state machine, a controlword per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage: each request on the req_ channel carries one controlword in
// req_tdata and the hardware fault flag in req_tuser. For every request the
// block returns exactly one response on the rsp_ channel with the statusword,
// the new state code and the operation-enabled flag.
// The request is first captured in an input register. When the result
// register can take a new value, the next-state logic updates the power
// state and the stored fault-reset bit and loads the result register, which
// drives rsp_tvalid. While the receiver keeps rsp_tready high, a new request
// can be taken in every cycle, so sustained throughput is one request per
// clock.
// If the receiver holds rsp_tready low, the response stays in the result
// register and the next request waits in the input register; req_tready
// falls only when both registers are full, and rises again in the cycle the
// response is taken.
// Reset (synchronous, active high) empties both registers, sets the power
// state to switch-on-disabled and clears the stored fault-reset bit.
// ----------------------------------------------------------------------------
module drive_power_state_machine
   import dpsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] control_word
   input  logic [0:0]  req_tuser,   // [0] hw_fault
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [15:0] status_word, [18:16] state_code,
                                    // [19] op_enabled, [23:20] zero
);

   // Input register.
   logic                in_valid_ff, in_valid_in;
   logic [CW_WIDTH-1:0] cw_ff;
   logic                fault_ff;

   // Drive state.
   power_state_type     state_ff, state_in;
   logic                prev_bit_ff, prev_bit_in;

   // Result register.
   logic                out_valid_ff, out_valid_in;
   dpsm_result_type     result_ff;
   dpsm_result_type     next_result;

   logic                advance;
   logic                load_out;

   dpsm_next u_next (
      .control_word   (cw_ff),
      .hw_fault       (fault_ff),
      .cur_state      (state_ff),
      .prev_reset_bit (prev_bit_ff),
      .result         (next_result)
   );

   // The result register can take a new value when empty or being drained.
   assign advance    = ~out_valid_ff | rsp_tready;
   assign load_out   = in_valid_ff & advance;
   assign req_tready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      state_in     = state_ff;
      prev_bit_in  = prev_bit_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
         in_valid_in  = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end
      if (load_out) begin
         state_in    = next_result.state_code;
         prev_bit_in = cw_ff[CW_FAULT_RESET_BIT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_DISABLED;
         prev_bit_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         prev_bit_ff  <= prev_bit_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         cw_ff    <= req_tdata;
         fault_ff <= req_tuser[0];
      end
      if (load_out) begin
         result_ff <= next_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, result_ff.op_enabled, result_ff.state_code,
                        result_ff.status_word};

endmodule

// ===== design/dpsm_next.sv =====
// ----------------------------------------------------------------------------
// Drive power state machine next-state logic
// Combinational transition and statusword decode for one controlword.
// ----------------------------------------------------------------------------
module dpsm_next
   import dpsm_pkg::*;
(
   input  logic [CW_WIDTH-1:0] control_word,
   input  logic                hw_fault,
   input  power_state_type     cur_state,
   input  logic                prev_reset_bit,
   output dpsm_result_type     result
);

   logic            reset_edge;
   logic [2:0]      low3;
   logic [3:0]      low4;
   power_state_type cmd_state;
   power_state_type new_state;

   assign low3       = control_word[2:0];
   assign low4       = control_word[3:0];
   assign reset_edge = control_word[CW_FAULT_RESET_BIT] & ~prev_reset_bit;

   // Standard transitions outside of the fault handling.
   always_comb begin
      cmd_state = cur_state;
      if (!control_word[CW_ENABLE_VOLT_BIT]) begin
         cmd_state = ST_DISABLED;
      end else begin
         case (cur_state)
            ST_DISABLED: begin
               if (low3 == CMD3_SHUTDOWN) cmd_state = ST_READY;
            end
            ST_READY: begin
               if (low3 == CMD3_SWITCH_ON) cmd_state = ST_SWITCHED_ON;
            end
            ST_SWITCHED_ON: begin
               if (low4 == CMD4_ENABLE_OP) cmd_state = ST_ENABLED;
               else if (low3 == CMD3_SHUTDOWN) cmd_state = ST_READY;
            end
            ST_ENABLED: begin
               if (!control_word[CW_QUICK_STOP_BIT]) cmd_state = ST_QUICK_STOP;
               else if (low4 == CMD4_DISABLE_OP) cmd_state = ST_SWITCHED_ON;
               else if (low3 == CMD3_SHUTDOWN) cmd_state = ST_READY;
            end
            ST_QUICK_STOP: begin
               if (low4 == CMD4_ENABLE_OP) cmd_state = ST_ENABLED;
               else if (low3 == CMD3_SHUTDOWN) cmd_state = ST_READY;
            end
            default: begin
               cmd_state = cur_state;
            end
         endcase
      end
   end

   // A hardware fault wins; fault is left only on a fault reset edge.
   always_comb begin
      if (hw_fault) begin
         new_state = ST_FAULT;
      end else if (cur_state == ST_FAULT) begin
         new_state = reset_edge ? ST_DISABLED : ST_FAULT;
      end else begin
         new_state = cmd_state;
      end
   end

   assign result.status_word = status_of(new_state);
   assign result.state_code  = new_state;
   assign result.op_enabled  = (new_state == ST_ENABLED);

endmodule

// ===== design/dpsm_checker.sv =====
// ----------------------------------------------------------------------------
// Drive power state machine checker
// Port-level assertions on both channels, bound to the top level.
// ----------------------------------------------------------------------------
module dpsm_checker
   import dpsm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   power_state_type rsp_state;
   assign rsp_state = power_state_type'(rsp_tdata[18:16]);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // No response is pending right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // The statusword matches the reported state.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] == status_of(rsp_state))
      else $error("statusword does not match state");

   // The operation-enabled flag tracks the enabled state.
   a_op_en: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[19] == (rsp_state == ST_ENABLED))
      else $error("op_enabled does not match state");

   // A receiver that is ready always lets a new request in.
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request blocked while the receiver is ready");

endmodule

bind drive_power_state_machine dpsm_checker u_dpsm_checker (.*);
